### design/pfe_pkg.sv
// Shared types, constants and helpers of the palette fade engine.
// Used by pfe_level_unit, pfe_palette_unit and palette_fade_engine; no dependencies.

package pfe_pkg;

  // Palette geometry
  localparam int NUM_COLORS  = 512;
  localparam int NUM_LEVELS  = 3 * NUM_COLORS;
  localparam int LEVEL_AW    = $clog2(NUM_LEVELS);
  localparam int COLOR_AW    = $clog2(NUM_COLORS);
  localparam int PAL_AW      = COLOR_AW + 1;
  localparam int PAL_DEPTH   = 2 ** PAL_AW;

  // Field widths
  localparam int LEVEL_W     = 16;
  localparam int COLOR_W     = 15;
  localparam int CHAN_W      = 5;
  localparam int FRAME_W     = 7;
  localparam int FADE_W      = 8;
  localparam int SLOT_IN_W   = 11;
  localparam int CIDX_IN_W   = 9;

  // Request kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Channel within one color
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [SLOT_IN_W-1:0] component_index;
    logic [LEVEL_W-1:0]   start_value;
    logic [LEVEL_W-1:0]   target_value;
    logic [LEVEL_W-1:0]   step_value;
    logic [FRAME_W-1:0]   frame_count;
    logic [CIDX_IN_W-1:0] color_index;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               fade_running;
    logic               shown_buffer;
    logic               tick_applied;
  } out_item_t;

  // Level slot write from a load request
  typedef struct packed {
    logic                en;
    logic [LEVEL_AW-1:0] slot;
    logic [LEVEL_W-1:0]  start;
    logic [LEVEL_W-1:0]  target;
    logic [LEVEL_W-1:0]  step;
  } load_req_t;

  // Kick-off of one frame sweep
  typedef struct packed {
    logic go;
    logic snap;
    logic bank;
  } sweep_cmd_t;

  // Palette write from the sweep
  typedef struct packed {
    logic               en;
    logic               last;
    logic [PAL_AW-1:0]  addr;
    logic [COLOR_W-1:0] data;
  } pal_wr_t;

  // Visible 5-bit channel of a fixed-point level
  function automatic logic [CHAN_W-1:0] level_chan(input logic [LEVEL_W-1:0] lvl);
    level_chan = lvl[14:10];
  endfunction

endpackage

### design/palette_fade_engine.sv
// Top level of the palette fade engine: request decode, fade counters, result register.
// Depends on pfe_pkg, pfe_level_unit and pfe_palette_unit.

// One request is taken when start is high and busy is low; each request gives exactly
// one result, shown on out_item for a single cycle with out_valid high, and the
// receiver cannot hold it off. A load, a start or a tick while no fade runs is answered
// from the idle state; a colour read passes a read state (registered palette read). A
// tick during a fade walks all 1536 levels through the single read port of the level
// store, one level a cycle, and writes each colour to the hidden palette bank as its
// blue level finishes; busy stays high meanwhile and the result follows with the bank
// swapped. No clearing pass is needed after reset; an unrendered bank reads as zero.

module palette_fade_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pfe_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pfe_pkg::out_item_t out_item
);
  import pfe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;

  logic [1:0]        state_r,     state_nxt;
  logic [FADE_W-1:0] fade_len_r,  fade_len_nxt;
  logic [FADE_W-1:0] prog_r,      prog_nxt;
  logic              shown_r,     shown_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r,  out_item_nxt;

  logic              accept;
  load_req_t         load_req;
  sweep_cmd_t        sweep_cmd;
  pal_wr_t           pal_wr;
  logic              sweep_done;
  logic              rd_en;
  logic [COLOR_W-1:0] rd_color_q;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  pfe_level_unit u_level (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_req   (load_req),
    .sweep_cmd  (sweep_cmd),
    .pal_wr     (pal_wr),
    .sweep_done (sweep_done)
  );

  pfe_palette_unit u_palette (
    .clk         (clk),
    .rst_n       (rst_n),
    .pal_wr      (pal_wr),
    .rd_en       (rd_en),
    .rd_bank     (shown_r),
    .rd_color    (COLOR_AW'(in_item.color_index)),
    .rd_in_range (in_item.color_index < NUM_COLORS),
    .color       (rd_color_q)
  );

  // Decode requests and sequence reads and sweeps
  always_comb begin
    state_nxt     = state_r;
    fade_len_nxt  = fade_len_r;
    prog_nxt      = prog_r;
    shown_nxt     = shown_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    load_req.en     = 1'b0;
    load_req.slot   = LEVEL_AW'(in_item.component_index);
    load_req.start  = in_item.start_value;
    load_req.target = in_item.target_value;
    load_req.step   = in_item.step_value;
    sweep_cmd.go    = 1'b0;
    sweep_cmd.snap  = 1'b0;
    sweep_cmd.bank  = ~shown_r;
    rd_en           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_item_nxt.color        = '0;
          out_item_nxt.fade_running = (fade_len_r != '0);
          out_item_nxt.shown_buffer = shown_r;
          out_item_nxt.tick_applied = 1'b0;
          unique case (in_item.kind)
            KIND_LOAD: begin
              load_req.en   = (in_item.component_index < NUM_LEVELS);
              out_valid_nxt = 1'b1;
            end
            KIND_START: begin
              fade_len_nxt              = FADE_W'(in_item.frame_count);
              prog_nxt                  = '0;
              out_item_nxt.fade_running = (in_item.frame_count != '0);
              out_valid_nxt             = 1'b1;
            end
            KIND_TICK: begin
              if (fade_len_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                prog_nxt       = prog_r + 1'b1;
                sweep_cmd.go   = 1'b1;
                sweep_cmd.snap = (prog_nxt >= fade_len_r);
                if (sweep_cmd.snap) begin
                  fade_len_nxt = '0;
                end
                state_nxt = ST_TICK;
              end
            end
            KIND_READ: begin
              rd_en     = 1'b1;
              state_nxt = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        out_item_nxt.color        = rd_color_q;
        out_item_nxt.fade_running = (fade_len_r != '0);
        out_item_nxt.shown_buffer = shown_r;
        out_item_nxt.tick_applied = 1'b0;
        out_valid_nxt             = 1'b1;
        state_nxt                 = ST_IDLE;
      end
      ST_TICK: begin
        if (sweep_done) begin
          shown_nxt                 = ~shown_r;
          out_item_nxt.color        = '0;
          out_item_nxt.fade_running = (fade_len_r != '0);
          out_item_nxt.shown_buffer = ~shown_r;
          out_item_nxt.tick_applied = 1'b1;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fade_len_r  <= '0;
      prog_r      <= '0;
      shown_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fade_len_r  <= fade_len_nxt;
      prog_r      <= prog_nxt;
      shown_r     <= shown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### design/pfe_level_unit.sv
// Level, target and step store with the frame sweep that updates it.
// Depends on pfe_pkg; feeds palette writes to pfe_palette_unit.

module pfe_level_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  pfe_pkg::load_req_t  load_req,
  input  pfe_pkg::sweep_cmd_t sweep_cmd,
  output pfe_pkg::pal_wr_t    pal_wr,
  output logic                sweep_done
);
  import pfe_pkg::*;

  localparam int WORD_W = 3 * LEVEL_W;

  logic [WORD_W-1:0]   mem [NUM_LEVELS];
  logic [WORD_W-1:0]   q_r;

  logic                run_r;
  logic                snap_r;
  logic                bank_r;
  logic [LEVEL_AW-1:0] rd_slot_r;
  logic [1:0]          rd_chan_r;
  logic [COLOR_AW-1:0] rd_color_r;

  logic                wv_r;
  logic [LEVEL_AW-1:0] wslot_r;
  logic [1:0]          wchan_r;
  logic [COLOR_AW-1:0] wcolor_r;
  logic                wlast_r;
  logic [CHAN_W-1:0]   red_r;
  logic [CHAN_W-1:0]   green_r;

  logic [LEVEL_W-1:0]  lvl;
  logic [LEVEL_W-1:0]  tgt;
  logic [LEVEL_W-1:0]  stp;
  logic [LEVEL_W-1:0]  new_lvl;
  logic                rd_last;
  logic                mem_we;
  logic [LEVEL_AW-1:0] mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  // Split the read word and compute the next level
  assign lvl     = q_r[WORD_W-1 -: LEVEL_W];
  assign tgt     = q_r[2*LEVEL_W-1 -: LEVEL_W];
  assign stp     = q_r[LEVEL_W-1:0];
  assign new_lvl = snap_r ? tgt : lvl + stp;
  assign rd_last = (rd_slot_r == LEVEL_AW'(NUM_LEVELS - 1));

  // Share the write port between loads and sweep write-back
  always_comb begin
    if (load_req.en) begin
      mem_we    = 1'b1;
      mem_waddr = load_req.slot;
      mem_wdata = {load_req.start, load_req.target, load_req.step};
    end else begin
      mem_we    = wv_r;
      mem_waddr = wslot_r;
      mem_wdata = {new_lvl, tgt, stp};
    end
  end

  // Store: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (run_r) begin
      q_r <= mem[rd_slot_r];
    end
  end

  // Sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      wv_r  <= 1'b0;
    end else begin
      wv_r <= run_r;
      if (sweep_cmd.go) begin
        run_r <= 1'b1;
      end else if (run_r && rd_last) begin
        run_r <= 1'b0;
      end
    end
  end

  // Advance read pointer and carry slot details to write-back
  always_ff @(posedge clk) begin
    if (sweep_cmd.go) begin
      snap_r     <= sweep_cmd.snap;
      bank_r     <= sweep_cmd.bank;
      rd_slot_r  <= '0;
      rd_chan_r  <= CH_RED;
      rd_color_r <= '0;
    end else if (run_r) begin
      rd_slot_r <= rd_slot_r + 1'b1;
      if (rd_chan_r == CH_BLUE) begin
        rd_chan_r  <= CH_RED;
        rd_color_r <= rd_color_r + 1'b1;
      end else begin
        rd_chan_r <= rd_chan_r + 1'b1;
      end
    end
    wslot_r  <= rd_slot_r;
    wchan_r  <= rd_chan_r;
    wcolor_r <= rd_color_r;
    wlast_r  <= rd_last;
    if (wv_r) begin
      case (wchan_r)
        CH_RED:   red_r   <= level_chan(new_lvl);
        CH_GREEN: green_r <= level_chan(new_lvl);
        default:  ;
      endcase
    end
  end

  // Pack one color once its blue level is done
  assign pal_wr.en   = wv_r && (wchan_r == CH_BLUE);
  assign pal_wr.last = wv_r && wlast_r;
  assign pal_wr.addr = {bank_r, wcolor_r};
  assign pal_wr.data = {red_r, green_r, level_chan(new_lvl)};
  assign sweep_done  = wv_r && wlast_r;

endmodule

### design/pfe_palette_unit.sv
// Double-buffered RGB555 palette store with per-bank rendered flags.
// Depends on pfe_pkg; written by pfe_level_unit, read for colour requests.

module pfe_palette_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfe_pkg::pal_wr_t                pal_wr,
  input  logic                            rd_en,
  input  logic                            rd_bank,
  input  logic [pfe_pkg::COLOR_AW-1:0]    rd_color,
  input  logic                            rd_in_range,
  output logic [pfe_pkg::COLOR_W-1:0]     color
);
  import pfe_pkg::*;

  logic [COLOR_W-1:0] mem [PAL_DEPTH];
  logic [COLOR_W-1:0] q_r;
  logic               ok_r;
  logic [1:0]         rendered_r;

  // A bank reads as zero until a full sweep has rendered it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rendered_r <= '0;
    end else if (pal_wr.en && pal_wr.last) begin
      rendered_r[pal_wr.addr[PAL_AW-1]] <= 1'b1;
    end
  end

  // Store: one write, one registered read
  always_ff @(posedge clk) begin
    if (pal_wr.en) begin
      mem[pal_wr.addr] <= pal_wr.data;
    end
    if (rd_en) begin
      q_r  <= mem[{rd_bank, rd_color}];
      ok_r <= rd_in_range && rendered_r[rd_bank];
    end
  end

  assign color = ok_r ? q_r : '0;

endmodule
